### src/bcmf_pkg.sv
// ----------------------------------------------------------------------------
// bcmf_pkg
// Shared constants and controller/datapath interface types for the border
// color mode finder.
// ----------------------------------------------------------------------------
package bcmf_pkg;

    localparam int BCMF_TABLE_ENTRIES = 64;
    localparam int BCMF_COUNT_BITS    = 12;
    localparam int COLOR_BITS         = 24;
    localparam int OUT_COUNT_BITS     = 12;
    localparam int OUT_COUNT_MAX      = 4095;

    // controller -> datapath
    typedef struct packed {
        logic load_pixel;   // capture the accepted request
        logic search_next;  // read entry idx+1 this cycle, else entry 0
        logic advance;      // step the search index
        logic hit;          // bump the count of the matching entry
        logic insert;       // store a new color or flag the overflow
        logic load_result;  // move the run result to the output, clear run
    } bcmf_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic used_zero;    // table holds no entries
        logic match;        // entry read back equals the pixel
        logic at_end;       // entry read back is the last valid one
        logic last;         // captured pixel closes the run
        logic out_free;     // output register can take a result
    } bcmf_status_t;

endpackage

### src/bcmf_ram.sv
// ----------------------------------------------------------------------------
// bcmf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/bcmf_datapath.sv
// ----------------------------------------------------------------------------
// bcmf_datapath
// Color table, search index, running leader and the output register.
// ----------------------------------------------------------------------------
module bcmf_datapath
    import bcmf_pkg::*;
#(
    parameter int TABLE_ENTRIES = BCMF_TABLE_ENTRIES,
    parameter int COUNT_BITS    = BCMF_COUNT_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bcmf_cmd_t                 cmd,
    output bcmf_status_t              status,
    input  logic [COLOR_BITS-1:0]     pixel_color,
    input  logic                      last_pixel,
    input  logic                      out_ready,
    output logic                      out_valid,
    output logic [COLOR_BITS-1:0]     background_color,
    output logic [OUT_COUNT_BITS-1:0] winning_count,
    output logic                      table_overflow
);

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int UW = $clog2(TABLE_ENTRIES + 1);
    localparam int EW = COLOR_BITS + COUNT_BITS;
    localparam int CW = (COUNT_BITS > OUT_COUNT_BITS) ? COUNT_BITS : OUT_COUNT_BITS;

    logic [COLOR_BITS-1:0]     color_reg;
    logic                      last_reg;
    logic [IW-1:0]             idx_reg, idx_next;
    logic [UW-1:0]             used_reg, used_next;
    logic [COLOR_BITS-1:0]     best_color_reg, best_color_next;
    logic [COUNT_BITS-1:0]     best_count_reg, best_count_next;
    logic                      ovf_reg, ovf_next;
    logic                      out_valid_reg, out_valid_next;
    logic [COLOR_BITS-1:0]     out_color_reg;
    logic [OUT_COUNT_BITS-1:0] out_count_reg;
    logic                      out_ovf_reg;

    logic                      ram_we;
    logic [IW-1:0]             ram_waddr, ram_raddr;
    logic [EW-1:0]             ram_wdata, ram_rdata;
    logic [COLOR_BITS-1:0]     rd_key;
    logic [COUNT_BITS-1:0]     rd_count, hit_count;
    logic                      full;
    logic [CW-1:0]             best_wide;
    logic [OUT_COUNT_BITS-1:0] best_clamped;

    bcmf_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[COUNT_BITS +: COLOR_BITS];
    assign rd_count  = ram_rdata[COUNT_BITS-1:0];
    assign hit_count = (rd_count == '1) ? rd_count : rd_count + COUNT_BITS'(1);
    assign full      = (used_reg == UW'(TABLE_ENTRIES));
    assign ram_raddr = cmd.search_next ? idx_reg + IW'(1) : '0;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = {color_reg, hit_count};
        if (cmd.hit)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.insert)
        begin
            ram_we    = !full;
            ram_waddr = used_reg[IW-1:0];
            ram_wdata = {color_reg, COUNT_BITS'(1)};
        end
    end

    always_comb
    begin
        idx_next        = idx_reg;
        used_next       = used_reg;
        best_color_next = best_color_reg;
        best_count_next = best_count_reg;
        ovf_next        = ovf_reg;

        if (cmd.load_pixel)
        begin
            idx_next = '0;
        end
        if (cmd.advance)
        begin
            idx_next = idx_reg + IW'(1);
        end
        if (cmd.hit && (hit_count > best_count_reg))
        begin
            best_color_next = color_reg;
            best_count_next = hit_count;
        end
        if (cmd.insert)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                used_next = used_reg + UW'(1);
                if (best_count_reg == '0)
                begin
                    best_color_next = color_reg;
                    best_count_next = COUNT_BITS'(1);
                end
            end
        end
        if (cmd.load_result)
        begin
            used_next       = '0;
            best_color_next = '0;
            best_count_next = '0;
            ovf_next        = 1'b0;
        end
    end

    // clamp the leader count to the output field
    assign best_wide    = CW'(best_count_reg);
    assign best_clamped = (best_wide > CW'(OUT_COUNT_MAX)) ? OUT_COUNT_BITS'(OUT_COUNT_MAX)
                                                           : best_wide[OUT_COUNT_BITS-1:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            used_reg       <= '0;
            best_color_reg <= '0;
            best_count_reg <= '0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            idx_reg        <= idx_next;
            used_reg       <= used_next;
            best_color_reg <= best_color_next;
            best_count_reg <= best_count_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pixel)
        begin
            color_reg <= pixel_color;
            last_reg  <= last_pixel;
        end
        if (cmd.load_result)
        begin
            out_color_reg <= best_color_reg;
            out_count_reg <= best_clamped;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign status.used_zero = (used_reg == '0);
    assign status.match     = (rd_key == color_reg);
    assign status.at_end    = (UW'(idx_reg) + UW'(1) == used_reg);
    assign status.last      = last_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign background_color = out_color_reg;
    assign winning_count    = out_count_reg;
    assign table_overflow   = out_ovf_reg;

endmodule

### src/bcmf_ctrl.sv
// ----------------------------------------------------------------------------
// bcmf_ctrl
// Sequencer: accept a pixel, walk the table one entry a cycle, then update,
// insert or drop, and hand the run result to the output register.
// ----------------------------------------------------------------------------
module bcmf_ctrl
    import bcmf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  bcmf_status_t status,
    output bcmf_cmd_t    cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_INSERT = 2'd2;
    localparam logic [1:0] S_WRAP   = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       done_tally;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_tally = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_pixel = 1'b1;
                    state_next     = status.used_zero ? S_INSERT : S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (status.match)
                begin
                    cmd.hit    = 1'b1;
                    done_tally = 1'b1;
                end
                else if (status.at_end)
                begin
                    cmd.insert = 1'b1;
                    done_tally = 1'b1;
                end
                else
                begin
                    // fetch the following entry while stepping the index
                    cmd.advance     = 1'b1;
                    cmd.search_next = 1'b1;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                done_tally = 1'b1;
            end
            S_WRAP:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (done_tally)
        begin
            state_next = status.last ? S_WRAP : S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

### src/border_color_mode_finder_unit.sv
// ----------------------------------------------------------------------------
// border_color_mode_finder_unit
// Most frequent color over a run of border pixels.
// ----------------------------------------------------------------------------
// Each pixel request is accepted while idle and then searched against the stored
// table entries; the table memory is read one entry per cycle through its single
// read port. The pixel that closes a run then loads the result, held back while a
// previous result still waits on the output. A new color that finds the table full
// is dropped and flagged; counts saturate and a tie goes to the color that reached
// the top count first. The table needs no clearing pass: only entries written
// during the current run are searched.
module border_color_mode_finder_unit
    import bcmf_pkg::*;
#(
    parameter int TABLE_ENTRIES = BCMF_TABLE_ENTRIES,
    parameter int COUNT_BITS    = BCMF_COUNT_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [COLOR_BITS-1:0]     pixel_color,
    input  logic                      last_pixel,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [COLOR_BITS-1:0]     background_color,
    output logic [OUT_COUNT_BITS-1:0] winning_count,
    output logic                      table_overflow
);

    bcmf_cmd_t    cmd;
    bcmf_status_t status;

    bcmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bcmf_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .pixel_color      (pixel_color),
        .last_pixel       (last_pixel),
        .out_ready        (out_ready),
        .out_valid        (out_valid),
        .background_color (background_color),
        .winning_count    (winning_count),
        .table_overflow   (table_overflow)
    );

endmodule

### src/bcmf_checker.sv
// ----------------------------------------------------------------------------
// bcmf_checker
// Port-level checks for the border color mode finder, bound to the top level.
// ----------------------------------------------------------------------------
module bcmf_checker
    import bcmf_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [COLOR_BITS-1:0]     pixel_color,
    input logic                      last_pixel,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [COLOR_BITS-1:0]     background_color,
    input logic [OUT_COUNT_BITS-1:0] winning_count,
    input logic                      table_overflow
);

    // a waiting request holds its payload
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(pixel_color)
            && $stable(last_pixel))
        else $error("waiting request changed");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(background_color)
            && $stable(winning_count) && $stable(table_overflow))
        else $error("stalled result changed");

    // every run counts at least one stored color
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> winning_count != '0)
        else $error("result with zero count");

    // an accepted request always needs a search or insert step
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after accepting a pixel");

    // a result is loaded only while no pixel can be taken
    a_load_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

endmodule

bind border_color_mode_finder_unit bcmf_checker u_bcmf_checker (.*);
